// ===== rtl/tod_pkg.sv =====
// Shared types and constants for the time-of-day arithmetic core.
package tod_pkg;

   typedef enum logic [1:0] {
      MODE_ADD_SEC  = 2'd0,
      MODE_FROM_MS  = 2'd1,
      MODE_DIFF_MS  = 2'd2,
      MODE_DIFF_SEC = 2'd3
   } mode_type;

   // Millisecond weights, all at most one day and so 27 bits wide.
   localparam logic [26:0] MS_PER_HOUR = 27'd3600000;
   localparam logic [26:0] MS_PER_MIN  = 27'd60000;
   localparam logic [26:0] MS_PER_SEC  = 27'd1000;
   localparam logic [26:0] MS_PER_DAY  = 27'd86400000;

   localparam logic signed [25:0] MS_PER_SEC_S   = 26'sd1000;
   localparam logic signed [17:0] SEC_PER_HOUR_S = 18'sd3600;
   localparam logic signed [17:0] SEC_PER_MIN_S  = 18'sd60;

   // Reciprocals m = ceil(2^S / d) with S = N + ceil(log2 d), which give an exact
   // floor(n / d) as (n * m) >> S for every n below 2^N.
   localparam int DAY_SHIFT  = 59;  // N = 32, d = one day
   localparam int HOUR_SHIFT = 49;  // N = 27, d = one hour
   localparam int MIN_SHIFT  = 38;  // N = 22, d = one minute
   localparam int SEC_SHIFT  = 26;  // N = 16, d = one second

   localparam logic [33:0] DAY_RECIP =
      34'(((64'd1 << DAY_SHIFT) + 64'd86399999) / 64'd86400000);
   localparam logic [28:0] HOUR_RECIP =
      29'(((64'd1 << HOUR_SHIFT) + 64'd3599999) / 64'd3600000);
   localparam logic [23:0] MIN_RECIP =
      24'(((64'd1 << MIN_SHIFT) + 64'd59999) / 64'd60000);
   localparam logic [17:0] SEC_RECIP =
      18'(((64'd1 << SEC_SHIFT) + 64'd999) / 64'd1000);

   typedef struct packed {
      mode_type          mode;
      logic [4:0]        a_hours;
      logic [5:0]        a_minutes;
      logic [5:0]        a_secs;
      logic [9:0]        a_millis;
      logic [4:0]        b_hours;
      logic [5:0]        b_minutes;
      logic [5:0]        b_secs;
      logic [9:0]        b_millis;
      logic signed [15:0] delta_seconds;
      logic [31:0]       ms_count;
   } req_type;

   // Per-beat results that ride alongside the time split.
   typedef struct packed {
      mode_type           mode;
      logic [26:0]        a_ms;
      logic signed [27:0] diff;
      logic               a_less_than_b;
      logic               a_equals_b;
      logic               a_is_zero;
   } side_type;

endpackage

// ===== rtl/tod_front.sv =====
// Front pipeline: weighted sums, differences, flags and day reduction.
module tod_front import tod_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  req_type     in_req,
   output logic        out_valid,
   output logic [26:0] out_value,
   output side_type    out_side
);

   function automatic logic [26:0] weighted_ms(input logic [4:0] h, input logic [5:0] m,
                                               input logic [5:0] s, input logic [9:0] ms);
      weighted_ms = 27'(h) * MS_PER_HOUR + 27'(m) * MS_PER_MIN + 27'(s) * MS_PER_SEC
                  + 27'(ms);
   endfunction

   // Stage 1
   logic [26:0]        a_ms_in, b_ms_in, b_ms1_ff;
   logic signed [25:0] delta_ms_in, delta_ms1_ff;
   logic [65:0]        cnt_prod;
   logic [5:0]         cnt_q_in, cnt_q1_ff;
   logic [31:0]        count1_ff;
   logic signed [17:0] dh, dm, ds, diff_sec_in;
   logic               lt_in;
   side_type           side1_in, side1_ff;
   logic               valid1_ff;

   // Stage 2
   logic [26:0]        a_mod_in, a_mod2_ff;
   logic [31:0]        cnt_qd_in, cnt_qd2_ff, count2_ff;
   logic signed [25:0] delta_ms2_ff;
   side_type           side2_in, side2_ff;
   logic               valid2_ff;

   // Stage 3
   logic signed [28:0] t_in, t3_ff;
   logic [31:0]        rem_full;
   logic [26:0]        rem_in, rem3_ff;
   side_type           side3_ff;
   logic               valid3_ff;

   // Stage 4
   logic [26:0]        v_in, v4_ff;
   side_type           side4_ff;
   logic               valid4_ff;

   always_comb begin
      a_ms_in     = weighted_ms(in_req.a_hours, in_req.a_minutes, in_req.a_secs,
                                in_req.a_millis);
      b_ms_in     = weighted_ms(in_req.b_hours, in_req.b_minutes, in_req.b_secs,
                                in_req.b_millis);
      delta_ms_in = 26'(in_req.delta_seconds) * MS_PER_SEC_S;
      cnt_prod    = 66'(in_req.ms_count) * 66'(DAY_RECIP);
      cnt_q_in    = cnt_prod[DAY_SHIFT+5:DAY_SHIFT];
      dh          = $signed(18'(in_req.a_hours))   - $signed(18'(in_req.b_hours));
      dm          = $signed(18'(in_req.a_minutes)) - $signed(18'(in_req.b_minutes));
      ds          = $signed(18'(in_req.a_secs))    - $signed(18'(in_req.b_secs));
      diff_sec_in = dh * SEC_PER_HOUR_S + dm * SEC_PER_MIN_S + ds;

      // Earlier-than is decided by the most significant field that differs.
      if (in_req.a_hours != in_req.b_hours) begin
         lt_in = in_req.a_hours < in_req.b_hours;
      end else if (in_req.a_minutes != in_req.b_minutes) begin
         lt_in = in_req.a_minutes < in_req.b_minutes;
      end else if (in_req.a_secs != in_req.b_secs) begin
         lt_in = in_req.a_secs < in_req.b_secs;
      end else begin
         lt_in = in_req.a_millis < in_req.b_millis;
      end

      side1_in.mode          = in_req.mode;
      side1_in.a_ms          = a_ms_in;
      side1_in.diff          = 28'(diff_sec_in);
      side1_in.a_less_than_b = lt_in;
      side1_in.a_equals_b    = (in_req.a_hours == in_req.b_hours) &&
                               (in_req.a_minutes == in_req.b_minutes) &&
                               (in_req.a_secs == in_req.b_secs) &&
                               (in_req.a_millis == in_req.b_millis);
      side1_in.a_is_zero     = (in_req.a_hours == 5'd0) && (in_req.a_minutes == 6'd0) &&
                               (in_req.a_secs == 6'd0) && (in_req.a_millis == 10'd0);
   end

   always_comb begin
      a_mod_in  = (side1_ff.a_ms >= MS_PER_DAY) ? side1_ff.a_ms - MS_PER_DAY : side1_ff.a_ms;
      cnt_qd_in = 32'(cnt_q1_ff) * 32'(MS_PER_DAY);
      side2_in  = side1_ff;
      case (side1_ff.mode)
         MODE_DIFF_MS:  side2_in.diff = $signed(28'(side1_ff.a_ms)) - $signed(28'(b_ms1_ff));
         MODE_DIFF_SEC: side2_in.diff = side1_ff.diff;
         default:       side2_in.diff = '0;
      endcase
   end

   always_comb begin
      t_in     = $signed(29'(a_mod2_ff)) + 29'(delta_ms2_ff);
      rem_full = count2_ff - cnt_qd2_ff;
      rem_in   = rem_full[26:0];
   end

   // A signed sum within one day either way of the range is folded back once.
   always_comb begin
      if (side3_ff.mode == MODE_ADD_SEC) begin
         if (t3_ff < 29'sd0) begin
            v_in = 27'(t3_ff + $signed(29'(MS_PER_DAY)));
         end else if (t3_ff >= $signed(29'(MS_PER_DAY))) begin
            v_in = 27'(t3_ff - $signed(29'(MS_PER_DAY)));
         end else begin
            v_in = 27'(t3_ff);
         end
      end else begin
         v_in = rem3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_ms1_ff     <= b_ms_in;
      delta_ms1_ff <= delta_ms_in;
      cnt_q1_ff    <= cnt_q_in;
      count1_ff    <= in_req.ms_count;
      side1_ff     <= side1_in;

      a_mod2_ff    <= a_mod_in;
      cnt_qd2_ff   <= cnt_qd_in;
      count2_ff    <= count1_ff;
      delta_ms2_ff <= delta_ms1_ff;
      side2_ff     <= side2_in;

      t3_ff        <= t_in;
      rem3_ff      <= rem_in;
      side3_ff     <= side2_ff;

      v4_ff        <= v_in;
      side4_ff     <= side3_ff;
   end

   assign out_valid = valid4_ff;
   assign out_value = v4_ff;
   assign out_side  = side4_ff;

endmodule

// ===== rtl/tod_split.sv =====
// Split pipeline: milliseconds of day into hours, minutes, seconds and milliseconds.
module tod_split import tod_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [26:0] in_value,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [4:0]  out_hours,
   output logic [5:0]  out_minutes,
   output logic [5:0]  out_secs,
   output logic [9:0]  out_millis,
   output side_type    out_side
);

   logic [5:0] valid_ff;
   side_type   side_ff [6];

   logic [55:0] h_prod;
   logic [4:0]  h_in, h1_ff, h2_ff, h3_ff, h4_ff, h5_ff;
   logic [26:0] v1_ff, hrem_full;
   logic [21:0] hrem_in, hrem2_ff, hrem3_ff;
   logic [45:0] m_prod;
   logic [5:0]  m_in, m3_ff, m4_ff, m5_ff;
   logic [21:0] mrem_full;
   logic [15:0] mrem_in, mrem4_ff, mrem5_ff;
   logic [33:0] s_prod;
   logic [5:0]  s_in, s5_ff;
   logic [15:0] srem_full;
   logic [9:0]  ms_in;
   logic        zero_time;

   logic [4:0]  hours_ff;
   logic [5:0]  minutes_ff, secs_ff;
   logic [9:0]  millis_ff;

   always_comb begin
      h_prod    = 56'(in_value) * 56'(HOUR_RECIP);
      h_in      = h_prod[HOUR_SHIFT+4:HOUR_SHIFT];
      hrem_full = v1_ff - 27'(h1_ff) * MS_PER_HOUR;
      hrem_in   = hrem_full[21:0];
      m_prod    = 46'(hrem2_ff) * 46'(MIN_RECIP);
      m_in      = m_prod[MIN_SHIFT+5:MIN_SHIFT];
      mrem_full = hrem3_ff - 22'(m3_ff) * 22'(MS_PER_MIN);
      mrem_in   = mrem_full[15:0];
      s_prod    = 34'(mrem4_ff) * 34'(SEC_RECIP);
      s_in      = s_prod[SEC_SHIFT+5:SEC_SHIFT];
      srem_full = mrem5_ff - 16'(s5_ff) * 16'(MS_PER_SEC);
      ms_in     = srem_full[9:0];
      // The difference modes report no time of day.
      zero_time = side_ff[4].mode inside {MODE_DIFF_MS, MODE_DIFF_SEC};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      for (int i = 1; i < 6; i++) begin
         side_ff[i] <= side_ff[i-1];
      end

      h1_ff    <= h_in;
      v1_ff    <= in_value;

      h2_ff    <= h1_ff;
      hrem2_ff <= hrem_in;

      h3_ff    <= h2_ff;
      hrem3_ff <= hrem2_ff;
      m3_ff    <= m_in;

      h4_ff    <= h3_ff;
      m4_ff    <= m3_ff;
      mrem4_ff <= mrem_in;

      h5_ff    <= h4_ff;
      m5_ff    <= m4_ff;
      mrem5_ff <= mrem4_ff;
      s5_ff    <= s_in;

      hours_ff   <= zero_time ? 5'd0  : h5_ff;
      minutes_ff <= zero_time ? 6'd0  : m5_ff;
      secs_ff    <= zero_time ? 6'd0  : s5_ff;
      millis_ff  <= zero_time ? 10'd0 : ms_in;
   end

   assign out_valid   = valid_ff[5];
   assign out_hours   = hours_ff;
   assign out_minutes = minutes_ff;
   assign out_secs    = secs_ff;
   assign out_millis  = millis_ff;
   assign out_side    = side_ff[5];

endmodule

// ===== rtl/time_of_day_arithmetic_core.sv =====
// Time-of-day arithmetic core: input register, front and split pipelines.
//
// A request beat is taken at a rising edge where start is high and busy is low.
// The mode selects adding signed seconds to time A (wrapping within the day),
// splitting a millisecond count taken modulo one day into H:M:S.ms, or A minus
// B in milliseconds or whole seconds. Every response also carries A as
// milliseconds of day and the flags A earlier than B, A equal to B, A is zero.
// The response beat shows on the rsp_ ports for one cycle with rsp_valid high,
// having passed one input register loaded at the accepting edge, four front
// stages and six split stages, one register after every constant multiply.
// One beat can be taken in every cycle while busy is low, and responses leave in request order.
// Busy is high only while reset is held and on the cycle after it; reset
// empties the pipeline so no response is emitted for beats in flight.
// The receiver cannot stall, so the pipeline never holds a beat back.
module time_of_day_arithmetic_core import tod_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [4:0]         req_a_hours,
   input  logic [5:0]         req_a_minutes,
   input  logic [5:0]         req_a_secs,
   input  logic [9:0]         req_a_millis,
   input  logic [4:0]         req_b_hours,
   input  logic [5:0]         req_b_minutes,
   input  logic [5:0]         req_b_secs,
   input  logic [9:0]         req_b_millis,
   input  logic signed [15:0] req_delta_seconds,
   input  logic [31:0]        req_ms_count,
   output logic               rsp_valid,
   output logic [4:0]         rsp_out_hours,
   output logic [5:0]         rsp_out_minutes,
   output logic [5:0]         rsp_out_secs,
   output logic [9:0]         rsp_out_millis,
   output logic signed [27:0] rsp_difference,
   output logic [26:0]        rsp_a_ms_of_day,
   output logic               rsp_a_less_than_b,
   output logic               rsp_a_equals_b,
   output logic               rsp_a_is_zero
);

   logic        busy_ff;
   logic        req_valid_ff;
   req_type     req_in, req_ff;
   logic        front_valid;
   logic [26:0] front_value;
   side_type    front_side, split_side;

   always_comb begin
      req_in.mode          = mode_type'(req_mode);
      req_in.a_hours       = req_a_hours;
      req_in.a_minutes     = req_a_minutes;
      req_in.a_secs        = req_a_secs;
      req_in.a_millis      = req_a_millis;
      req_in.b_hours       = req_b_hours;
      req_in.b_minutes     = req_b_minutes;
      req_in.b_secs        = req_b_secs;
      req_in.b_millis      = req_b_millis;
      req_in.delta_seconds = req_delta_seconds;
      req_in.ms_count      = req_ms_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= start && !busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         req_ff <= req_in;
      end
   end

   tod_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid_ff),
      .in_req    (req_ff),
      .out_valid (front_valid),
      .out_value (front_value),
      .out_side  (front_side)
   );

   tod_split u_split (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (front_valid),
      .in_value    (front_value),
      .in_side     (front_side),
      .out_valid   (rsp_valid),
      .out_hours   (rsp_out_hours),
      .out_minutes (rsp_out_minutes),
      .out_secs    (rsp_out_secs),
      .out_millis  (rsp_out_millis),
      .out_side    (split_side)
   );

   assign busy              = busy_ff;
   assign rsp_difference    = split_side.diff;
   assign rsp_a_ms_of_day   = split_side.a_ms;
   assign rsp_a_less_than_b = split_side.a_less_than_b;
   assign rsp_a_equals_b    = split_side.a_equals_b;
   assign rsp_a_is_zero     = split_side.a_is_zero;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the time-of-day arithmetic core.
module tb import tod_pkg::*; ();

   localparam longint DAY_MS       = 64'd86400000;
   localparam longint HOUR_MS      = 64'd3600000;
   localparam longint MINUTE_MS    = 64'd60000;
   localparam longint SECOND_MS    = 64'd1000;
   localparam int     RANDOM_BEATS = 950;
   localparam int     SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] secs;
      logic [9:0] millis;
   } tod_time_type;

   typedef struct packed {
      tod_time_type       tod;
      logic signed [27:0] difference;
      logic [26:0]        a_ms_of_day;
      logic               a_less_than_b;
      logic               a_equals_b;
      logic               a_is_zero;
   } tod_answer_type;

   typedef struct {
      req_type        beat;
      bit             typed;
      tod_answer_type want;
   } tod_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_mode = '0;
   logic [4:0]         req_a_hours = '0;
   logic [5:0]         req_a_minutes = '0;
   logic [5:0]         req_a_secs = '0;
   logic [9:0]         req_a_millis = '0;
   logic [4:0]         req_b_hours = '0;
   logic [5:0]         req_b_minutes = '0;
   logic [5:0]         req_b_secs = '0;
   logic [9:0]         req_b_millis = '0;
   logic signed [15:0] req_delta_seconds = '0;
   logic [31:0]        req_ms_count = '0;
   logic               rsp_valid;
   logic [4:0]         rsp_out_hours;
   logic [5:0]         rsp_out_minutes;
   logic [5:0]         rsp_out_secs;
   logic [9:0]         rsp_out_millis;
   logic signed [27:0] rsp_difference;
   logic [26:0]        rsp_a_ms_of_day;
   logic               rsp_a_less_than_b;
   logic               rsp_a_equals_b;
   logic               rsp_a_is_zero;

   tod_answer_type pending_answers[$];
   tod_row_type    directed_rows[$];
   int             fail_count = 0;

   time_of_day_arithmetic_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_a_hours       (req_a_hours),
      .req_a_minutes     (req_a_minutes),
      .req_a_secs        (req_a_secs),
      .req_a_millis      (req_a_millis),
      .req_b_hours       (req_b_hours),
      .req_b_minutes     (req_b_minutes),
      .req_b_secs        (req_b_secs),
      .req_b_millis      (req_b_millis),
      .req_delta_seconds (req_delta_seconds),
      .req_ms_count      (req_ms_count),
      .rsp_valid         (rsp_valid),
      .rsp_out_hours     (rsp_out_hours),
      .rsp_out_minutes   (rsp_out_minutes),
      .rsp_out_secs      (rsp_out_secs),
      .rsp_out_millis    (rsp_out_millis),
      .rsp_difference    (rsp_difference),
      .rsp_a_ms_of_day   (rsp_a_ms_of_day),
      .rsp_a_less_than_b (rsp_a_less_than_b),
      .rsp_a_equals_b    (rsp_a_equals_b),
      .rsp_a_is_zero     (rsp_a_is_zero)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic tod_time_type hms(int h, int m, int s, int ms);
      tod_time_type t;
      t.hours   = 5'(h);
      t.minutes = 6'(m);
      t.secs    = 6'(s);
      t.millis  = 10'(ms);
      return t;
   endfunction

   function automatic req_type make_req(mode_type mode, tod_time_type a, tod_time_type b,
                                        logic signed [15:0] delta, logic [31:0] count);
      req_type r;
      r.mode          = mode;
      r.a_hours       = a.hours;
      r.a_minutes     = a.minutes;
      r.a_secs        = a.secs;
      r.a_millis      = a.millis;
      r.b_hours       = b.hours;
      r.b_minutes     = b.minutes;
      r.b_secs        = b.secs;
      r.b_millis      = b.millis;
      r.delta_seconds = delta;
      r.ms_count      = count;
      return r;
   endfunction

   function automatic tod_answer_type answer(tod_time_type t, int diff, int a_ms,
                                             bit lt, bit eq, bit zero);
      tod_answer_type w;
      w.tod           = t;
      w.difference    = 28'(diff);
      w.a_ms_of_day   = 27'(a_ms);
      w.a_less_than_b = lt;
      w.a_equals_b    = eq;
      w.a_is_zero     = zero;
      return w;
   endfunction

   function automatic void add_row(req_type beat, bit typed, tod_answer_type want);
      tod_row_type row;
      row.beat  = beat;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   function automatic longint ms_of(tod_time_type t);
      return longint'(t.hours) * HOUR_MS + longint'(t.minutes) * MINUTE_MS
           + longint'(t.secs) * SECOND_MS + longint'(t.millis);
   endfunction

   function automatic tod_time_type split_day(longint v);
      tod_time_type t;
      v = v % DAY_MS;
      t.hours   = 5'(v / HOUR_MS);
      v = v % HOUR_MS;
      t.minutes = 6'(v / MINUTE_MS);
      v = v % MINUTE_MS;
      t.secs    = 6'(v / SECOND_MS);
      t.millis  = 10'(v % SECOND_MS);
      return t;
   endfunction

   function automatic tod_answer_type predict_tod(req_type r);
      tod_time_type   a;
      tod_time_type   b;
      longint         a_ms;
      longint         diff;
      longint         shifted;
      tod_answer_type w;
      a    = hms(r.a_hours, r.a_minutes, r.a_secs, r.a_millis);
      b    = hms(r.b_hours, r.b_minutes, r.b_secs, r.b_millis);
      w    = '0;
      diff = 0;
      a_ms = ms_of(a);
      case (r.mode)
         MODE_ADD_SEC: begin
            // An out-of-range A is folded into the day before the seconds are added.
            shifted = (a_ms % DAY_MS) + longint'($signed(r.delta_seconds)) * SECOND_MS;
            shifted = shifted % DAY_MS;
            if (shifted < 0) shifted += DAY_MS;
            w.tod = split_day(shifted);
         end
         MODE_FROM_MS: w.tod = split_day(longint'(r.ms_count));
         MODE_DIFF_MS: diff = a_ms - ms_of(b);
         default: begin
            diff = (longint'(a.hours) - longint'(b.hours)) * 3600
                 + (longint'(a.minutes) - longint'(b.minutes)) * 60
                 + (longint'(a.secs) - longint'(b.secs));
         end
      endcase
      if (a.hours != b.hours) w.a_less_than_b = a.hours < b.hours;
      else if (a.minutes != b.minutes) w.a_less_than_b = a.minutes < b.minutes;
      else if (a.secs != b.secs) w.a_less_than_b = a.secs < b.secs;
      else w.a_less_than_b = a.millis < b.millis;
      w.difference  = diff[27:0];
      w.a_ms_of_day = a_ms[26:0];
      w.a_equals_b  = (a == b);
      w.a_is_zero   = (a == '0);
      return w;
   endfunction

   // Mostly legal values, now and then anything the field width allows.
   function automatic int draw_unit(int hi, int bits);
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, (1 << bits) - 1);
      return $urandom_range(0, hi);
   endfunction

   function automatic tod_time_type random_time();
      if ($urandom_range(0, 15) == 0) return '0;
      return hms(draw_unit(23, 5), draw_unit(59, 6), draw_unit(59, 6), draw_unit(999, 10));
   endfunction

   function automatic void note_mismatch(string field, longint want, longint got);
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
   endfunction

   // Presents one beat and waits for the edge that takes it; a nonzero gap then drops start and idles before returning.
   task automatic issue_beat(req_type beat, tod_answer_type want, int gap);
      req_mode          <= beat.mode;
      req_a_hours       <= beat.a_hours;
      req_a_minutes     <= beat.a_minutes;
      req_a_secs        <= beat.a_secs;
      req_a_millis      <= beat.a_millis;
      req_b_hours       <= beat.b_hours;
      req_b_minutes     <= beat.b_minutes;
      req_b_secs        <= beat.b_secs;
      req_b_millis      <= beat.b_millis;
      req_delta_seconds <= beat.delta_seconds;
      req_ms_count      <= beat.ms_count;
      start             <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      pending_answers.push_back(want);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_pending();
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      tod_answer_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_answers.size() == 0) begin
            $error("response beat with no request outstanding");
            fail_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_out_hours !== want.tod.hours)
               note_mismatch("out_hours", want.tod.hours, rsp_out_hours);
            if (rsp_out_minutes !== want.tod.minutes)
               note_mismatch("out_minutes", want.tod.minutes, rsp_out_minutes);
            if (rsp_out_secs !== want.tod.secs)
               note_mismatch("out_secs", want.tod.secs, rsp_out_secs);
            if (rsp_out_millis !== want.tod.millis)
               note_mismatch("out_millis", want.tod.millis, rsp_out_millis);
            if (rsp_difference !== want.difference)
               note_mismatch("difference", $signed(want.difference), $signed(rsp_difference));
            if (rsp_a_ms_of_day !== want.a_ms_of_day)
               note_mismatch("a_ms_of_day", want.a_ms_of_day, rsp_a_ms_of_day);
            if (rsp_a_less_than_b !== want.a_less_than_b)
               note_mismatch("a_less_than_b", want.a_less_than_b, rsp_a_less_than_b);
            if (rsp_a_equals_b !== want.a_equals_b)
               note_mismatch("a_equals_b", want.a_equals_b, rsp_a_equals_b);
            if (rsp_a_is_zero !== want.a_is_zero)
               note_mismatch("a_is_zero", want.a_is_zero, rsp_a_is_zero);
         end
      end
   end

   initial begin : stimulus
      tod_time_type       midnight;
      tod_time_type       day_end;
      tod_time_type       all_ones;
      tod_time_type       a_time;
      tod_time_type       b_time;
      req_type            beat;
      logic signed [15:0] delta;
      logic [31:0]        count;
      int                 keep;
      bit                 idle_on;

      midnight = hms(0, 0, 0, 0);
      day_end  = hms(23, 59, 59, 999);
      all_ones = hms(31, 63, 63, 1023);
      idle_on  = 1'b0;

      // Wrap across midnight in both directions and the extremes of the offset.
      add_row(make_req(MODE_ADD_SEC, midnight, midnight, -16'sd1, 32'd0), 1'b1,
              answer(hms(23, 59, 59, 0), 0, 0, 1'b0, 1'b1, 1'b1));
      add_row(make_req(MODE_ADD_SEC, day_end, midnight, 16'sd1, 32'd0), 1'b1,
              answer(hms(0, 0, 0, 999), 0, 86399999, 1'b0, 1'b0, 1'b0));
      add_row(make_req(MODE_ADD_SEC, midnight, midnight, 16'sd32767, 32'd0), 1'b1,
              answer(hms(9, 6, 7, 0), 0, 0, 1'b0, 1'b1, 1'b1));
      add_row(make_req(MODE_ADD_SEC, midnight, midnight, -16'sd32768, 32'd0), 1'b0, '0);
      add_row(make_req(MODE_ADD_SEC, day_end, all_ones, -16'sd32768, 32'hFFFF_FFFF),
              1'b0, '0);
      add_row(make_req(MODE_ADD_SEC, hms(0, 0, 0, 5), midnight, -16'sd1, 32'd0), 1'b0, '0);
      add_row(make_req(MODE_ADD_SEC, all_ones, midnight, 16'sd0, 32'd0), 1'b0, '0);
      // Millisecond counts around one day and at the top of the range.
      add_row(make_req(MODE_FROM_MS, midnight, midnight, 16'sd0, 32'd0), 1'b1,
              answer(midnight, 0, 0, 1'b0, 1'b1, 1'b1));
      add_row(make_req(MODE_FROM_MS, midnight, midnight, 16'sd0, 32'd86399999), 1'b1,
              answer(day_end, 0, 0, 1'b0, 1'b1, 1'b1));
      add_row(make_req(MODE_FROM_MS, midnight, midnight, 16'sd0, 32'd86400000), 1'b1,
              answer(midnight, 0, 0, 1'b0, 1'b1, 1'b1));
      add_row(make_req(MODE_FROM_MS, midnight, midnight, -16'sd1, 32'hFFFF_FFFF), 1'b0, '0);
      add_row(make_req(MODE_FROM_MS, hms(5, 5, 5, 5), hms(5, 5, 5, 6), 16'sd0,
                       32'h8000_0000), 1'b0, '0);
      // Largest differences either way, in milliseconds and in seconds.
      add_row(make_req(MODE_DIFF_MS, day_end, midnight, 16'sd0, 32'd0), 1'b1,
              answer(midnight, 86399999, 86399999, 1'b0, 1'b0, 1'b0));
      add_row(make_req(MODE_DIFF_MS, midnight, day_end, 16'sd0, 32'd0), 1'b1,
              answer(midnight, -86399999, 0, 1'b1, 1'b0, 1'b1));
      add_row(make_req(MODE_DIFF_SEC, day_end, midnight, 16'sd0, 32'd0), 1'b1,
              answer(midnight, 86399, 86399999, 1'b0, 1'b0, 1'b0));
      add_row(make_req(MODE_DIFF_SEC, midnight, day_end, 16'sd0, 32'd0), 1'b1,
              answer(midnight, -86399, 0, 1'b1, 1'b0, 1'b1));
      // The seconds difference drops milliseconds; the ordering flag does not.
      add_row(make_req(MODE_DIFF_SEC, hms(12, 30, 15, 999), hms(12, 30, 15, 0), 16'sd0,
                       32'd0), 1'b0, '0);
      add_row(make_req(MODE_DIFF_MS, hms(12, 34, 56, 789), hms(12, 34, 56, 789), 16'sd0,
                       32'd0), 1'b0, '0);
      add_row(make_req(MODE_DIFF_MS, hms(7, 15, 0, 0), hms(7, 16, 0, 0), 16'sd0, 32'd0),
              1'b0, '0);
      add_row(make_req(MODE_DIFF_MS, hms(7, 16, 20, 500), hms(7, 16, 21, 0), 16'sd0,
                       32'd0), 1'b0, '0);
      add_row(make_req(MODE_DIFF_MS, all_ones, midnight, 16'sd0, 32'd0), 1'b0, '0);
      add_row(make_req(MODE_DIFF_SEC, midnight, all_ones, 16'sd0, 32'd0), 1'b0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue_beat(directed_rows[i].beat,
                    directed_rows[i].typed ? directed_rows[i].want
                                           : predict_tod(directed_rows[i].beat),
                    $urandom_range(0, 5));
      drain_pending();

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
         if (n == RANDOM_BEATS / 2) drain_pending();
         a_time = random_time();
         b_time = random_time();
         // Share a leading run of fields so the ordering flag is decided at every level.
         keep = $urandom_range(0, 4);
         if (keep >= 1) b_time.hours = a_time.hours;
         if (keep >= 2) b_time.minutes = a_time.minutes;
         if (keep >= 3) b_time.secs = a_time.secs;
         if (keep == 4) b_time.millis = a_time.millis;
         if ($urandom_range(0, 3) == 0) delta = 16'(int'($urandom_range(0, 200)) - 100);
         else delta = 16'($urandom);
         if ($urandom_range(0, 1) == 0) count = $urandom;
         else count = $urandom_range(0, 172800000);
         beat = make_req(mode_type'($urandom_range(0, 3)), a_time, b_time, delta, count);
         issue_beat(beat, predict_tod(beat), idle_on ? $urandom_range(0, 5) : 0);
      end

      drain_pending();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_answers.size() == 0)
         $display("time_of_day_arithmetic_core verification clean");
      else
         $display("time_of_day_arithmetic_core verification failed");
      $finish;
   end

   initial begin : watchdog
      #1000000;
      $display("time_of_day_arithmetic_core verification failed");
      $finish;
   end

endmodule
